[rtl/core/pwm_frequency_duty_meter_assert.svh]
// assertion macros for the pwm meter
`ifndef PWM_FREQUENCY_DUTY_METER_ASSERT_SVH
`define PWM_FREQUENCY_DUTY_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define PFDM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfdm assertion failed");
`define PFDM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfdm assertion failed");
`else
`define PFDM_ASSERT_NOW(name, ante, cons)
`define PFDM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/core/pfdm_pkg.sv]
`default_nettype none
package pfdm_pkg;

  localparam int CLK_W      = 27;
  localparam int DUTY_W     = 7;
  localparam int SPAN_OUT_W = 17;
  localparam int CAP_W      = 16;
  localparam int CNT_W      = 5;
  localparam int DSH_PAD_W  = CLK_W - DUTY_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(8000000);
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);

  localparam logic REG_TIMER_CLK = 1'b0;

  typedef enum logic {
    CMD_CAPTURE,
    CMD_OVERFLOW
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FDIV,
    BK_MUL,
    BK_SCALE,
    BK_DCHK,
    BK_DDIV,
    BK_DSAT,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[rtl/core/pwm_frequency_duty_meter.sv]
// a rising-edge transaction passes a 27-step frequency quotient, multiply, scale and 7-step
// duty quotient before out_valid rises, the duty quotient skipped when the duty needs no
// division and all skipped for a zero period; the back end's shared restoring divider runs
// one rising edge at a time, popping the next only once the result is loaded;
// overflow and falling-edge transactions go in every cycle while the 2-entry queue has room
// reset: synchronous, active low; clears edge tracking, queue and result valid, clock reg 8000000
`default_nettype none
`include "pwm_frequency_duty_meter_assert.svh"
module pwm_frequency_duty_meter
  import pfdm_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [0:0]            in_command,
  input  wire logic [CAP_W-1:0]      in_capture_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [CLK_W-1:0]      out_frequency_hz,
  output logic      [DUTY_W-1:0]     out_duty_percent,
  output logic      [SPAN_OUT_W-1:0] out_period_ticks,
  output logic      [SPAN_OUT_W-1:0] out_high_ticks,
  output logic                       out_zero_period,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready
);

  localparam int SPAN_W = COUNTER_WIDTH + 1;

  logic [CLK_W-1:0]    clk_hz_r;
  logic                reg_sel;
  q_stat_t             q_stat;
  logic                q_push;
  logic                q_pop;
  logic [SPAN_W-1:0]   f_period;
  logic [SPAN_W-1:0]   f_high;
  logic [2*SPAN_W-1:0] q_data;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_TIMER_CLK);
  assign prdata  = reg_sel ? DATA_W'(clk_hz_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      clk_hz_r <= pwdata[CLK_W-1:0];
    end
  end

  pfdm_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_capture_value(in_capture_value),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_period        (f_period),
    .q_high          (f_high)
  );

  pfdm_fifo #(
    .WIDTH(2 * SPAN_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_period, f_high}),
    .pop      (q_pop),
    .pop_data (q_data),
    .stat     (q_stat)
  );

  pfdm_back #(
    .SPAN_W(SPAN_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .clk_hz          (clk_hz_r),
    .q_valid         (!q_stat.empty),
    .q_period        (q_data[2*SPAN_W-1:SPAN_W]),
    .q_high          (q_data[SPAN_W-1:0]),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frequency_hz(out_frequency_hz),
    .out_duty_percent(out_duty_percent),
    .out_period_ticks(out_period_ticks),
    .out_high_ticks  (out_high_ticks),
    .out_zero_period (out_zero_period)
  );

  `PFDM_ASSERT_NOW(a_no_push_when_full, q_push, !q_stat.full)
  `PFDM_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_stat.empty)
  `PFDM_ASSERT_NEXT(a_push_fills_queue, q_push && q_stat.empty, !q_stat.empty)
  `PFDM_ASSERT_NOW(a_zero_res, out_valid && out_zero_period, ~|{out_frequency_hz, out_duty_percent})
  `PFDM_ASSERT_NOW(a_duty_in_range, out_valid, out_duty_percent <= DUTY_FULL)

endmodule
`default_nettype wire

[rtl/core/pfdm_fifo.sv]
`default_nettype none
module pfdm_fifo
  import pfdm_pkg::*;
#(
  parameter int WIDTH = 34
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output q_stat_t               stat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule
`default_nettype wire

[rtl/core/pfdm_front.sv]
`default_nettype none
module pfdm_front
  import pfdm_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16,
  localparam int SPAN_W = COUNTER_WIDTH + 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [0:0]        in_command,
  input  wire logic [CAP_W-1:0]  in_capture_value,
  input  wire q_stat_t           q_stat,
  output logic                   q_push,
  output logic      [SPAN_W-1:0] q_period,
  output logic      [SPAN_W-1:0] q_high
);

  localparam int TOP_W = COUNTER_WIDTH + 2;

  logic                     expect_falling_r, expect_falling_nxt;
  logic                     wrapped_r, wrapped_nxt;
  logic [COUNTER_WIDTH-1:0] start_r, start_nxt;
  logic [SPAN_W-1:0]        high_r, high_nxt;
  logic [COUNTER_WIDTH-1:0] cap;
  logic [SPAN_W-1:0]        span;
  logic                     accept;

  // span from the period start, one wrap tracked
  always_comb begin
    logic [TOP_W-1:0] full;
    logic [TOP_W-1:0] top;
    full = TOP_W'(1) << COUNTER_WIDTH;
    cap  = COUNTER_WIDTH'(in_capture_value);
    top  = TOP_W'(cap) + (wrapped_r ? full : '0);
    if (top < TOP_W'(start_r)) begin
      top = top + full;
    end
    span = SPAN_W'(top - TOP_W'(start_r));
  end

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    expect_falling_nxt = expect_falling_r;
    wrapped_nxt        = wrapped_r;
    start_nxt          = start_r;
    high_nxt           = high_r;
    q_push             = 1'b0;
    if (accept) begin
      if (in_command == CMD_OVERFLOW) begin
        wrapped_nxt = 1'b1;
      end else if (expect_falling_r) begin
        high_nxt           = span;
        wrapped_nxt        = 1'b0;
        expect_falling_nxt = 1'b0;
      end else begin
        q_push             = 1'b1;
        start_nxt          = cap;
        wrapped_nxt        = 1'b0;
        expect_falling_nxt = 1'b1;
      end
    end
  end

  assign q_period = span;
  assign q_high   = high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_falling_r <= 1'b0;
      wrapped_r        <= 1'b0;
      start_r          <= '0;
      high_r           <= '0;
    end else begin
      expect_falling_r <= expect_falling_nxt;
      wrapped_r        <= wrapped_nxt;
      start_r          <= start_nxt;
      high_r           <= high_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pfdm_back.sv]
`default_nettype none
module pfdm_back
  import pfdm_pkg::*;
#(
  parameter int SPAN_W = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CLK_W-1:0]      clk_hz,
  input  wire logic                  q_valid,
  input  wire logic [SPAN_W-1:0]     q_period,
  input  wire logic [SPAN_W-1:0]     q_high,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [CLK_W-1:0]      out_frequency_hz,
  output logic      [DUTY_W-1:0]     out_duty_percent,
  output logic      [SPAN_OUT_W-1:0] out_period_ticks,
  output logic      [SPAN_OUT_W-1:0] out_high_ticks,
  output logic                       out_zero_period
);

  localparam int DW     = (SPAN_W > CLK_W) ? SPAN_W : CLK_W;
  localparam int PROD_W = SPAN_W + CLK_W;
  localparam int P100_W = PROD_W + DUTY_W;

  back_state_t state_r, state_nxt;

  logic [SPAN_W-1:0] period_r;
  logic [SPAN_W-1:0] high_r;
  logic              zero_r;
  logic [CLK_W-1:0]  freq_r;
  logic [DUTY_W-1:0] duty_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     div_r;
  logic [CLK_W-1:0]  dsh_r;
  logic [CLK_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod_r;
  logic [P100_W-1:0] p100_r;
  logic              out_valid_r;

  logic [DW:0] trial;
  logic        ge;
  logic        duty_zero;
  logic        duty_sat;
  logic        div_step;
  logic        ld_out;
  logic        last_step;

  // one restoring division step
  assign trial     = {rem_r, dsh_r[CLK_W-1]};
  assign ge        = (trial >= {1'b0, div_r});
  assign last_step = (cnt_r == CNT_W'(1));
  assign duty_zero = (high_r == '0) || (freq_r == '0);
  assign duty_sat  = (p100_r >= P100_W'({clk_hz, DUTY_W'(0)}));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_period == '0) ? BK_FIN : BK_FDIV;
        end
      end
      BK_FDIV: begin
        if (last_step) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:   state_nxt = BK_SCALE;
      BK_SCALE: state_nxt = BK_DCHK;
      BK_DCHK: begin
        state_nxt = (duty_zero || duty_sat) ? BK_FIN : BK_DDIV;
      end
      BK_DDIV: begin
        if (last_step) begin
          state_nxt = BK_DSAT;
        end
      end
      BK_DSAT:  state_nxt = BK_FIN;
      BK_FIN: begin
        if (ld_out) begin
          state_nxt = BK_IDLE;
        end
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    div_step = 1'b0;
    ld_out   = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop    = q_valid;
      BK_FDIV: div_step = 1'b1;
      BK_DDIV: div_step = 1'b1;
      BK_FIN:  ld_out   = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      period_r <= q_period;
      high_r   <= q_high;
      zero_r   <= (q_period == '0);
      freq_r   <= '0;
      duty_r   <= '0;
      rem_r    <= '0;
      div_r    <= DW'(q_period);
      dsh_r    <= clk_hz;
      quo_r    <= '0;
      cnt_r    <= CNT_W'(CLK_W);
    end
    if (div_step) begin
      rem_r <= ge ? DW'(trial - {1'b0, div_r}) : DW'(trial);
      dsh_r <= {dsh_r[CLK_W-2:0], 1'b0};
      quo_r <= {quo_r[CLK_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    unique case (state_r)
      BK_MUL: begin
        freq_r <= quo_r;
        prod_r <= PROD_W'(high_r) * PROD_W'(quo_r);
      end
      BK_SCALE: begin
        p100_r <= P100_W'(prod_r) * P100_W'(DUTY_FULL);
      end
      BK_DCHK: begin
        if (duty_zero) begin
          duty_r <= '0;
        end else if (duty_sat) begin
          duty_r <= DUTY_FULL;
        end else begin
          rem_r <= DW'(p100_r >> DUTY_W);
          dsh_r <= {p100_r[DUTY_W-1:0], DSH_PAD_W'(0)};
          div_r <= DW'(clk_hz);
          quo_r <= '0;
          cnt_r <= CNT_W'(DUTY_W);
        end
      end
      BK_DSAT: begin
        duty_r <= (quo_r[DUTY_W-1:0] > DUTY_FULL) ? DUTY_FULL : quo_r[DUTY_W-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_frequency_hz <= freq_r;
      out_duty_percent <= duty_r;
      out_period_ticks <= SPAN_OUT_W'(period_r);
      out_high_ticks   <= SPAN_OUT_W'(high_r);
      out_zero_period  <= zero_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
